// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation and status codes, sequencer states and the shared-unit command.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPW  = 3;
   localparam int STW  = 2;
   localparam int MAGW = 64;
   localparam int SHW  = 7;

   typedef enum logic [OPW-1:0] {
      OP_NORM = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef enum logic [STW-1:0] {
      ST_OK    = 2'd0,
      ST_DIVZ  = 2'd1,
      ST_OVFL  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_GINIT, S_GTWO, S_GODD,
      S_GLOOP, S_GSUB, S_GSHL, S_DVINIT, S_DVSTEP, S_DVNEXT, S_CHECK, S_OUT
   } state_type;

   // Command to the shared divider.
   typedef struct packed {
      logic       div_go;
   } alu_cmd_type;

endpackage

// File: rtl/rau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic divider
// Restoring division of a 64-bit magnitude, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rau_pkg::MAGW-1:0]  dividend,
   input  logic [rau_pkg::MAGW-1:0]  divisor,
   output logic                      done,
   output logic [rau_pkg::MAGW-1:0]  quotient
);
   import rau_pkg::*;

   logic [MAGW-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [SHW-1:0]  cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [MAGW:0]   trial;
   logic [MAGW-1:0] shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[MAGW-2:0], quo_ff[MAGW-1]};
      trial   = {1'b0, shifted} - {1'b0, dvs_ff};
      if (rem_ff[MAGW-1]) begin
         trial = {1'b1, shifted} - {1'b0, dvs_ff};
      end
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = SHW'(MAGW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[MAGW] || rem_ff[MAGW-1]) begin
            rem_in = trial[MAGW-1:0];
            quo_in = {quo_ff[MAGW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[MAGW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SHW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/rational_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or normalizes fractions, reduced.
// ----------------------------------------------------------------------------
// One item at a time. An item passes through the products and sum, a binary
// gcd over 64-bit magnitudes that works by shifts and subtract steps, and two
// 64-bit restoring divisions in a shared divider, one for the numerator and
// one for the denominator. Errors found on entry go straight to the output.
// req_tready is high only when the unit is idle and no result waits.
module rational_arith_unit #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
   input  logic [127:0] req_tdata,
   // req_tuser: req_type[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata: res_num[31:0], res_den[62:32], status[64:63], zeros above
   output logic [71:0] rsp_tdata
);
   import rau_pkg::*;

   localparam logic [MAGW-1:0] LIM = (MAGW'(1) << (WIDTH - 1)) - MAGW'(1);

   state_type state_ff, state_in;
   logic [31:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic        ann, adn, bnn, bdn;
   logic [31:0] anm, adm, bnm, bdm;
   op_type      op_ff;
   logic [MAGW-1:0] x_ff, x_in, y_ff, y_in, p0_ff, p0_in, nm_ff, nm_in;
   logic [MAGW-1:0] dm_ff, dm_in;
   logic        p0n_ff, p0n_in, nn_ff, nn_in, dn_ff, dn_in, neg_ff, neg_in;
   logic [SHW-1:0] sh_ff, sh_in;
   logic        half_ff, half_in;
   logic [31:0] ma, mb;
   logic [63:0] prod;
   logic        mneg;
   logic [31:0] onum_ff, onum_in;
   logic [30:0] oden_ff, oden_in;
   logic [1:0]  ost_ff, ost_in;
   logic        ov_ff, ov_in;
   logic [MAGW-1:0] g_ff, g_in;
   logic        dv_start, dv_done;
   logic [MAGW-1:0] dv_a, dv_q;
   alu_cmd_type cmd;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (~v + 32'd1) : v;
   endfunction

   assign ann = an_ff[31];
   assign adn = ad_ff[31];
   assign bdn = bd_ff[31];
   assign bnn = (op_ff == OP_SUB) ? (!bn_ff[31] && bn_ff != '0) : bn_ff[31];
   assign anm = mag32(an_ff);
   assign adm = mag32(ad_ff);
   assign bnm = mag32(bn_ff);
   assign bdm = mag32(bd_ff);

   // Shared 32x32 multiplier; operands chosen by the sequencer.
   always_comb begin
      ma = anm; mb = bdm; mneg = ann ^ bdn;
      case (state_ff)
         S_MUL0: begin
            if (op_ff == OP_MUL) begin
               mb = bnm; mneg = ann ^ bnn;
            end
         end
         S_MUL1: begin
            ma = bnm; mb = adm; mneg = bnn ^ adn;
         end
         S_MUL2: begin
            ma = adm; mb = bdm; mneg = adn ^ bdn;
            if (op_ff == OP_DIV) begin
               mb = bnm; mneg = adn ^ bnn;
            end
         end
         default: ;
      endcase
      prod = {32'd0, ma} * {32'd0, mb};
   end

   assign cmd.div_go = dv_start;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid && req_tready) state_in = S_MUL0;
         S_MUL0:   begin
            if (ad_ff == '0 || (op_ff != OP_NORM && bd_ff == '0) ||
                (op_ff == OP_DIV && bn_ff == '0)) state_in = S_OUT;
            else state_in = S_MUL1;
         end
         S_MUL1:   state_in = S_MUL2;
         S_MUL2:   state_in = S_SUM;
         S_SUM:    state_in = S_GINIT;
         S_GINIT:  state_in = (nm_ff == '0) ? S_OUT : S_GTWO;
         S_GTWO:   if (x_ff[0] || y_ff[0]) state_in = S_GODD;
         S_GODD:   if (x_ff[0]) state_in = S_GLOOP;
         S_GLOOP:  begin
            if (y_ff == '0) state_in = S_GSHL;
            else if (y_ff[0]) state_in = S_GSUB;
         end
         S_GSUB:   state_in = S_GLOOP;
         S_GSHL:   state_in = S_DVINIT;
         S_DVINIT: state_in = S_DVSTEP;
         S_DVSTEP: if (dv_done) state_in = half_ff ? S_CHECK : S_DVNEXT;
         S_DVNEXT: state_in = S_DVSTEP;
         S_CHECK:  state_in = S_OUT;
         S_OUT:    if (!ov_ff) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; p0_in = p0_ff; p0n_in = p0n_ff;
      nm_in = nm_ff; dm_in = dm_ff; nn_in = nn_ff; dn_in = dn_ff;
      neg_in = neg_ff; sh_in = sh_ff; half_in = half_ff;
      onum_in = onum_ff; oden_in = oden_ff; ost_in = ost_ff; ov_in = ov_ff;
      g_in = g_ff; dv_start = 1'b0; dv_a = nm_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         S_MUL0: begin
            p0_in = prod; p0n_in = mneg && prod != '0;
            if (op_ff != OP_ADD && op_ff != OP_SUB && op_ff != OP_MUL &&
                op_ff != OP_DIV) begin
               p0_in = {32'd0, anm}; p0n_in = ann;
            end
            if (ad_ff == '0 || (op_ff != OP_NORM && bd_ff == '0) ||
                (op_ff == OP_DIV && bn_ff == '0)) begin
               onum_in = '0; oden_in = '0; ost_in = ST_DIVZ; ov_in = 1'b1;
            end
         end
         S_MUL1: begin
            x_in = prod; nn_in = mneg && prod != '0;
         end
         S_MUL2: begin
            dm_in = prod; dn_in = mneg;
            if (op_ff != OP_ADD && op_ff != OP_SUB && op_ff != OP_MUL &&
                op_ff != OP_DIV) begin
               dm_in = {32'd0, adm}; dn_in = adn;
            end
         end
         S_SUM: begin
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               if (p0n_ff == nn_ff) begin
                  nm_in = p0_ff + x_ff; nn_in = p0n_ff;
               end else if (p0_ff >= x_ff) begin
                  nm_in = p0_ff - x_ff; nn_in = p0n_ff;
               end else begin
                  nm_in = x_ff - p0_ff; nn_in = nn_ff;
               end
            end else begin
               nm_in = p0_ff; nn_in = p0n_ff;
            end
         end
         S_GINIT: begin
            neg_in = nn_ff ^ dn_ff;
            x_in = nm_ff; y_in = dm_ff; sh_in = '0;
            if (nm_ff == '0) begin
               onum_in = '0; oden_in = 31'd1; ost_in = ST_OK; ov_in = 1'b1;
            end
         end
         S_GTWO: if (!(x_ff[0] || y_ff[0])) begin
            x_in = x_ff >> 1; y_in = y_ff >> 1; sh_in = sh_ff + 1'b1;
         end
         S_GODD: if (!x_ff[0]) x_in = x_ff >> 1;
         S_GLOOP: if (y_ff != '0 && !y_ff[0]) y_in = y_ff >> 1;
         S_GSUB: begin
            if (x_ff > y_ff) begin
               x_in = y_ff; y_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         S_GSHL: g_in = x_ff << sh_ff;
         S_DVINIT: begin
            dv_start = 1'b1; dv_a = nm_ff; half_in = 1'b0;
         end
         S_DVSTEP: if (dv_done) begin
            if (half_ff) dm_in = dv_q; else nm_in = dv_q;
         end
         S_DVNEXT: begin
            dv_start = 1'b1; dv_a = dm_ff; half_in = 1'b1;
         end
         S_CHECK: begin
            ov_in = 1'b1;
            if (dm_ff > LIM || (neg_ff ? nm_ff > LIM + 1'b1 : nm_ff > LIM)) begin
               onum_in = '0; oden_in = '0; ost_in = ST_OVFL;
            end else begin
               onum_in = neg_ff ? (~nm_ff[31:0] + 32'd1) : nm_ff[31:0];
               oden_in = dm_ff[30:0]; ost_in = ST_OK;
            end
         end
         default: ;
      endcase
   end

   rau_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_go),
      .dividend (dv_a),
      .divisor  (g_ff),
      .done     (dv_done),
      .quotient (dv_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      if (req_tvalid && req_tready) begin
         an_ff <= req_tdata[31:0];
         ad_ff <= req_tdata[63:32];
         bn_ff <= req_tdata[95:64];
         bd_ff <= req_tdata[127:96];
         // Unused operation codes behave as normalize.
         op_ff <= (req_tuser > OP_DIV) ? OP_NORM : op_type'(req_tuser);
      end
      x_ff <= x_in; y_ff <= y_in; p0_ff <= p0_in; p0n_ff <= p0n_in;
      nm_ff <= nm_in; dm_ff <= dm_in; nn_ff <= nn_in; dn_ff <= dn_in;
      neg_ff <= neg_in; sh_ff <= sh_in; half_ff <= half_in; g_ff <= g_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ost_ff <= ost_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {7'd0, ost_ff, oden_ff, onum_ff};

endmodule

// File: dv/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Streams fraction operations into the unit with random idle cycles on both
// sides, predicts each reduced result and status, and compares in order.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
   import rau_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } frac_req_type;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0]  status;
   } frac_rsp_type;

   localparam longint LIMIT = 5000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   frac_req_type pending_q[$];
   frac_rsp_type answer_q[$];
   int        errors = 0;
   bit        calm = 1'b0;
   bit        feed_done = 1'b0;
   longint    cycles = 0;

   rational_arith_unit #(.WIDTH(32)) u_dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] bin_gcd(input logic [63:0] x, input logic [63:0] y);
      int sh;
      logic [63:0] t;
      sh = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 1) == 0) begin
         x >>= 1; y >>= 1; sh++;
      end
      while (!x[0]) x >>= 1;
      while (y != 0) begin
         while (!y[0]) y >>= 1;
         if (x > y) begin
            t = x; x = y; y = t;
         end
         y -= x;
      end
      return x << sh;
   endfunction

   // Exact signed arithmetic in 128 bits; products stay below 2^63.
   function automatic frac_rsp_type reduce_frac(input frac_req_type r);
      frac_rsp_type o;
      logic [2:0] k;
      logic signed [127:0] an, ad, bn, bd, n, d;
      logic [63:0] nm, dm, g;
      logic neg;
      o = '0;
      k = (r.kind > OP_DIV) ? OP_NORM : r.kind;
      an = $signed(r.a_num); ad = $signed(r.a_den);
      bn = $signed(r.b_num); bd = $signed(r.b_den);
      if (ad == 0 || (k != OP_NORM && bd == 0) || (k == OP_DIV && bn == 0)) begin
         o.status = ST_DIVZ;
         return o;
      end
      case (k)
         OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         OP_MUL: begin n = an * bn; d = ad * bd; end
         OP_DIV: begin n = an * bd; d = ad * bn; end
         default: begin n = an; d = ad; end
      endcase
      if (n == 0) begin
         o.den = 31'd1;
         return o;
      end
      neg = (n < 0) != (d < 0);
      nm = (n < 0) ? 64'(-n) : 64'(n);
      dm = (d < 0) ? 64'(-d) : 64'(d);
      g = bin_gcd(nm, dm);
      nm = nm / g; dm = dm / g;
      if (dm > 64'h7FFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
         o.status = ST_OVFL;
         return o;
      end
      o.num = neg ? 32'(-nm) : nm[31:0];
      o.den = dm[30:0];
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(0);
         3: return 32'($signed($urandom_range(0, 20)) - 10);
         4, 5: return $urandom;
         default: return 32'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   task automatic add_item(input logic [2:0] k, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd);
      pending_q.push_back('{k, an, ad, bn, bd});
   endtask

   initial begin
      logic [31:0] v;
      // Directed: every operation, extremes, zero denominators, overflow.
      add_item(OP_NORM, 32'd6, -32'sd4, 0, 0);
      add_item(OP_NORM, 32'h8000_0000, 32'h8000_0000, 0, 0);
      add_item(OP_NORM, 32'h8000_0000, -32'sd1, 0, 0);
      add_item(OP_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      add_item(OP_NORM, 32'd5, 32'd0, 1, 1);
      add_item(OP_NORM, 32'd0, -32'sd7, 1, 0);
      add_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      add_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
      add_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
      add_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      add_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      add_item(OP_SUB, -32'sd3, 32'd4, 32'h8000_0000, 32'h8000_0000);
      add_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_item(OP_MUL, 32'h7FFF_FFFF, 32'd3, 32'd3, 32'h7FFF_FFFF);
      add_item(OP_MUL, 32'd0, 32'd3, -32'sd5, 32'd7);
      add_item(OP_MUL, 32'h0001_0000, 32'd1, 32'h0001_0000, 32'd1);
      add_item(OP_DIV, 32'd3, 32'd4, -32'sd9, 32'd8);
      add_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd8);
      add_item(OP_DIV, 32'd1, 32'd1, 32'h8000_0000, -32'sd1);
      add_item(OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_item(3'd5, 32'd10, 32'd4, 0, 0);
      add_item(3'd6, -32'sd10, -32'sd4, 0, 0);
      add_item(3'd7, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
      for (int i = 0; i < 1400; i++) begin
         v = $urandom;
         add_item(3'($urandom_range(0, 7)), pick_value(), pick_value() | 32'(v[0]),
                  pick_value(), pick_value() | 32'(v[1]));
      end
      feed_done = 1'b1;
   end

   // Driver.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == 12) reset <= 1'b0;
      if (cycles == 200) calm <= 1'b1;
      if (cycles == 30000) calm <= 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            answer_q.push_back(reduce_frac(pending_q.pop_front()));
         end
         if ((!req_tvalid || req_tready)) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_q[0].kind;
               req_tdata  <= {pending_q[0].b_den, pending_q[0].b_num,
                              pending_q[0].a_den, pending_q[0].a_num};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm || $urandom_range(0, 99) >= 15;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      frac_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answer_q.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            errors++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_tdata[31:0] !== want.num) begin
               $error("res_num expected %0d got %0d", $signed(want.num),
                      $signed(rsp_tdata[31:0]));
               errors++;
            end
            if (rsp_tdata[62:32] !== want.den) begin
               $error("res_den expected %0d got %0d", want.den, rsp_tdata[62:32]);
               errors++;
            end
            if (rsp_tdata[64:63] !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_tdata[64:63]);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (feed_done);
      while ((pending_q.size() != 0 || answer_q.size() != 0) && cycles < LIMIT)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (cycles >= LIMIT) begin
         $display("rational_arith_unit_tb: FAIL");
      end else if (errors == 0 && answer_q.size() == 0) begin
         $display("rational_arith_unit_tb: PASS");
      end else begin
         $display("rational_arith_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
